// File: hdl/graph_reachability_query_top_macros.svh
// Assertion macros shared by the graph reachability query block.
`ifndef GRAPH_REACHABILITY_QUERY_TOP_MACROS_SVH
`define GRAPH_REACHABILITY_QUERY_TOP_MACROS_SVH
`ifndef SYNTH
// Checked on every clock edge outside reset.
`define GRQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define GRQ_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRQ_ASSERT(name, prop, msg)
`define GRQ_ASSERT_NR(name, prop, msg)
`endif
`endif

// File: hdl/grq_pkg.sv
// Types, constants and helper functions of the graph reachability query block.
package grq_pkg;

  localparam int ROW_W = 64;
  localparam int VTX_W = 6;
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] VC_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } grq_op_t;

  typedef struct packed {
    grq_op_t          op;
    logic [VTX_W-1:0] edge_from;
    logic [VTX_W-1:0] edge_to;
    logic [VTX_W-1:0] query_start;
    logic [VTX_W-1:0] query_target;
  } grq_in_t;

  typedef struct packed {
    logic reachable;
    logic status;
  } grq_out_t;

  typedef struct packed {
    logic             start;
    logic [VTX_W-1:0] start_vtx;
    logic [VTX_W-1:0] target_vtx;
    logic [ROW_W-1:0] mask;
  } grq_bfs_ctl_t;

  typedef struct packed {
    logic             busy;
    logic             rd_en;
    logic [VTX_W-1:0] rd_vtx;
    logic             done;
    logic             reachable;
  } grq_bfs_stat_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [VTX_W-1:0] grq_ffs(input logic [ROW_W-1:0] v);
    logic [VTX_W-1:0] idx;
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = VTX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: hdl/graph_reachability_query_top.sv
// Path from accept to output word: clear, unused op or rejected vertex go straight to the
// response state; add edge reads the row, then writes it back in the edge state; query runs
// the search, which reads one adjacency row per cycle from the RAM, until the frontier is empty.
// One word is in work at a time; the next is taken once the result sits in the output stage.
// Synchronous active-low reset empties the matrix at once through per-row valid bits,
// sets vertex_count to 64 and leaves the output channel empty.
module graph_reachability_query_top
  import grq_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  grq_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output grq_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  `include "graph_reachability_query_top_macros.svh"

  localparam int ROWS = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
  localparam int AW   = $clog2(ROWS);
  localparam logic [CNT_W-1:0] ROWS_C = CNT_W'(ROWS);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EDGE   = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_RESP   = 4'b1000
  } grq_state_t;

  grq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] vc_r, vc_nxt;
  logic [ROWS-1:0]  row_vld_r, row_vld_nxt;
  logic             out_valid_r, out_valid_nxt;
  grq_out_t         out_data_r, out_data_nxt;
  grq_out_t         res_r, res_nxt;
  logic [VTX_W-1:0] from_r, from_nxt;
  logic [VTX_W-1:0] to_r, to_nxt;
  logic [AW-1:0]    rd_addr_r;

  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic [ROW_W-1:0] ram_wr_data;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  logic [ROW_W-1:0] ram_rd_data;
  logic [ROW_W-1:0] row_q;

  logic [CNT_W-1:0] lim;
  logic [ROW_W-1:0] lim_mask;
  logic             in_accept;
  logic             edge_bad;
  logic             query_bad;

  grq_bfs_ctl_t     bfs_ctl;
  grq_bfs_stat_t    bfs_stat;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Rows never written since the last clear read as empty.
  assign row_q = row_vld_r[rd_addr_r] ? ram_rd_data : '0;

  always_comb begin
    lim = (vc_r < ROWS_C) ? vc_r : ROWS_C;
    for (int i = 0; i < ROW_W; i++) begin
      lim_mask[i] = (CNT_W'(i) < lim);
    end
    edge_bad  = ({1'b0, in_data.edge_from} >= lim) || ({1'b0, in_data.edge_to} >= lim);
    query_bad = ({1'b0, in_data.query_start} >= lim)
             || ({1'b0, in_data.query_target} >= lim);
  end

  always_comb begin
    state_nxt     = state_r;
    vc_nxt        = cfg_wr_en ? cfg_wr_data : vc_r;
    row_vld_nxt   = row_vld_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    res_nxt       = res_r;
    from_nxt      = from_r;
    to_nxt        = to_r;

    ram_rd_en   = 1'b0;
    ram_rd_addr = bfs_stat.rd_vtx[AW-1:0];
    ram_wr_en   = 1'b0;
    ram_wr_addr = from_r[AW-1:0];
    ram_wr_data = row_q | (ROW_W'(1) << to_r);

    bfs_ctl.start      = 1'b0;
    bfs_ctl.start_vtx  = in_data.query_start;
    bfs_ctl.target_vtx = in_data.query_target;
    bfs_ctl.mask       = lim_mask;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          res_nxt   = '0;
          state_nxt = ST_RESP;
          case (in_data.op)
            OP_CLEAR: begin
              row_vld_nxt = '0;
            end
            OP_ADD: begin
              if (edge_bad) begin
                res_nxt.status = 1'b1;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = in_data.edge_from[AW-1:0];
                from_nxt    = in_data.edge_from;
                to_nxt      = in_data.edge_to;
                state_nxt   = ST_EDGE;
              end
            end
            OP_QUERY: begin
              if (query_bad) begin
                res_nxt.status = 1'b1;
              end else begin
                bfs_ctl.start = 1'b1;
                state_nxt     = ST_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EDGE: begin
        ram_wr_en                     = 1'b1;
        row_vld_nxt[from_r[AW-1:0]] = 1'b1;
        state_nxt                     = ST_RESP;
      end
      ST_SEARCH: begin
        ram_rd_en = bfs_stat.rd_en;
        if (bfs_stat.done) begin
          res_nxt.reachable = bfs_stat.reachable;
          state_nxt         = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vc_r        <= VC_RESET;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vc_r        <= vc_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    res_r      <= res_nxt;
    from_r     <= from_nxt;
    to_r       <= to_nxt;
    if (ram_rd_en) begin
      rd_addr_r <= ram_rd_addr;
    end
  end

  grq_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ROWS)
  ) u_adj_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  grq_bfs u_bfs (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (bfs_ctl),
    .row_data(row_q),
    .stat    (bfs_stat)
  );

  `GRQ_ASSERT(a_wr_in_range, ram_wr_en |-> (int'(ram_wr_addr) < ROWS), "row write beyond matrix")
  `GRQ_ASSERT(a_search_busy, (state_r == ST_SEARCH) |-> bfs_stat.busy, "search state without engine")
  `GRQ_ASSERT(a_out_from_resp, $rose(out_valid_r) |-> $past(state_r == ST_RESP), "word without result")

endmodule

// File: hdl/grq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module grq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/grq_bfs.sv
// Reachability search engine: visited and frontier bitmaps, one row read per cycle.
module grq_bfs
  import grq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  grq_bfs_ctl_t     ctl,
  input  logic [ROW_W-1:0] row_data,
  output grq_bfs_stat_t    stat
);

  `include "graph_reachability_query_top_macros.svh"

  logic             busy_r, busy_nxt;
  logic             pend_r, pend_nxt;
  logic [ROW_W-1:0] frontier_r, frontier_nxt;
  logic [ROW_W-1:0] visited_r, visited_nxt;
  logic [ROW_W-1:0] mask_r, mask_nxt;
  logic [VTX_W-1:0] target_r, target_nxt;

  logic [ROW_W-1:0] fresh;
  logic [ROW_W-1:0] frontier_cur;
  logic [ROW_W-1:0] visited_cur;
  logic [VTX_W-1:0] pick;

  // The row requested last cycle arrives now and is folded in before the next pick.
  always_comb begin
    fresh        = pend_r ? (row_data & mask_r & ~visited_r) : '0;
    frontier_cur = frontier_r | fresh;
    visited_cur  = visited_r | fresh;
    pick         = grq_ffs(frontier_cur);

    busy_nxt     = busy_r;
    pend_nxt     = 1'b0;
    frontier_nxt = frontier_r;
    visited_nxt  = visited_r;
    mask_nxt     = mask_r;
    target_nxt   = target_r;

    stat.busy      = busy_r;
    stat.rd_en     = 1'b0;
    stat.rd_vtx    = pick;
    stat.done      = 1'b0;
    stat.reachable = visited_cur[target_r];

    if (ctl.start) begin
      busy_nxt     = 1'b1;
      frontier_nxt = ROW_W'(1) << ctl.start_vtx;
      visited_nxt  = ROW_W'(1) << ctl.start_vtx;
      mask_nxt     = ctl.mask;
      target_nxt   = ctl.target_vtx;
    end else if (busy_r) begin
      visited_nxt = visited_cur;
      if (frontier_cur != '0) begin
        stat.rd_en   = 1'b1;
        pend_nxt     = 1'b1;
        frontier_nxt = frontier_cur & ~(ROW_W'(1) << pick);
      end else begin
        stat.done    = 1'b1;
        busy_nxt     = 1'b0;
        frontier_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frontier_r <= frontier_nxt;
    visited_r  <= visited_nxt;
    mask_r     <= mask_nxt;
    target_r   <= target_nxt;
  end

  `GRQ_ASSERT(a_rd_only_busy, stat.rd_en |-> busy_r, "row read outside a search")
  `GRQ_ASSERT(a_done_ends_search, stat.done |=> !busy_r, "search still busy after done")
  `GRQ_ASSERT(a_no_restart, ctl.start |-> !busy_r, "search started while one is running")
  `GRQ_ASSERT_NR(a_done_no_read, stat.done |-> !stat.rd_en, "row read in the finishing cycle")

endmodule
